// ===== rtl/core/challoc_pkg.sv =====
`timescale 1ns / 1ps

package challoc_pkg;

	localparam int CHANNELS   = 16;
	localparam int WAIT_DEPTH = 32;

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
	localparam int ENTRY_W = 17;

	typedef enum logic [1:0] {
		CMD_PLAY   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STARTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_REJECTED = 3'd2,
		ST_FREED    = 3'd3,
		ST_HANDED   = 3'd4,
		ST_STOPPED  = 3'd5,
		ST_CLEARED  = 3'd6
	} stat_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic  capture;
		logic  exec;
		stat_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic any_free;
		logic q_empty;
		logic q_full;
		logic fin_ok;
	} dp_status_t;

	// low 4 bits of a channel number, zero-extended for small channel counts
	function automatic logic [3:0] chan_to_out(input logic [CH_W-1:0] idx);
		logic [CH_W+3:0] t;
		t = (CH_W + 4)'(idx);
		return t[3:0];
	endfunction

	function automatic logic [CH_W-1:0] fin_to_idx(input logic [3:0] fin);
		logic [CH_W+3:0] t;
		t = (CH_W + 4)'(fin);
		return t[CH_W-1:0];
	endfunction

endpackage

// ===== rtl/core/channel_allocator_with_wait_queue.sv =====
`timescale 1ns / 1ps

// Channel allocator with a FIFO wait queue. A command beat is taken when start is high and
// busy is low; it is captured into the command registers, and its single result is
// registered from the execute cycle onto status, channel_out, started_sound and
// started_repeats, flagged by done for exactly one cycle; it cannot be held off. A beat
// is not taken during the execute cycle, in which the lowest-free-channel search and
// the queue update happen while the registered read of the queue memory supplies the
// oldest waiter. busy is high only during the execute cycle.

module channel_allocator_with_wait_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [7:0]        sound_id,
	input  logic signed [8:0] repeat_count,
	input  logic [3:0]        finished_channel,
	output logic              done,
	output logic [2:0]        status,
	output logic [3:0]        channel_out,
	output logic [7:0]        started_sound,
	output logic signed [8:0] started_repeats
);

	challoc_pkg::ctrl_cmd_t  ctl;
	challoc_pkg::dp_status_t st;

	challoc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	challoc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.st               (st),
		.cmd              (cmd),
		.sound_id         (sound_id),
		.repeat_count     (repeat_count),
		.finished_channel (finished_channel),
		.done             (done),
		.status           (status),
		.channel_out      (channel_out),
		.started_sound    (started_sound),
		.started_repeats  (started_repeats)
	);

endmodule

// ===== rtl/core/challoc_ram.sv =====
`timescale 1ns / 1ps

module challoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/challoc_ctrl.sv =====
`timescale 1ns / 1ps

module challoc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  challoc_pkg::dp_status_t st,
	output challoc_pkg::ctrl_cmd_t  ctl,
	output logic                    busy
);

	challoc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= challoc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			challoc_pkg::S_IDLE: begin
				if (start) begin
					state_d = challoc_pkg::S_EXEC;
				end
			end
			challoc_pkg::S_EXEC: state_d = challoc_pkg::S_IDLE;
			default: state_d = challoc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.capture = 1'b0;
		ctl.exec    = 1'b0;
		ctl.op      = challoc_pkg::ST_CLEARED;
		busy        = 1'b0;
		case (state_q)
			challoc_pkg::S_IDLE: begin
				ctl.capture = start;
			end
			challoc_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				busy     = 1'b1;
				case (st.cmd)
					challoc_pkg::CMD_PLAY: begin
						if (st.any_free) begin
							ctl.op = challoc_pkg::ST_STARTED;
						end else if (st.q_full) begin
							ctl.op = challoc_pkg::ST_REJECTED;
						end else begin
							ctl.op = challoc_pkg::ST_QUEUED;
						end
					end
					challoc_pkg::CMD_FINISH: begin
						// out-of-range channel never dequeues a waiter
						if (!st.fin_ok || st.q_empty) begin
							ctl.op = challoc_pkg::ST_FREED;
						end else begin
							ctl.op = challoc_pkg::ST_HANDED;
						end
					end
					challoc_pkg::CMD_STOP:  ctl.op = challoc_pkg::ST_STOPPED;
					challoc_pkg::CMD_CLEAR: ctl.op = challoc_pkg::ST_CLEARED;
					default:                ctl.op = challoc_pkg::ST_CLEARED;
				endcase
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/challoc_dp.sv =====
`timescale 1ns / 1ps

module challoc_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  challoc_pkg::ctrl_cmd_t  ctl,
	output challoc_pkg::dp_status_t st,
	input  logic [1:0]              cmd,
	input  logic [7:0]              sound_id,
	input  logic signed [8:0]       repeat_count,
	input  logic [3:0]              finished_channel,
	output logic                    done,
	output logic [2:0]              status,
	output logic [3:0]              channel_out,
	output logic [7:0]              started_sound,
	output logic signed [8:0]       started_repeats
);

	// captured beat
	challoc_pkg::cmd_t cmd_q;
	logic [7:0]        sound_q;
	logic [8:0]        reps_q;
	logic [3:0]        fin_q;

	logic [challoc_pkg::CHANNELS-1:0] chan_busy_q;
	logic [challoc_pkg::PTR_W-1:0]    head_q, tail_q;
	logic [challoc_pkg::CNT_W-1:0]    count_q;
	logic                             done_q;

	logic [challoc_pkg::CH_W-1:0]    free_idx;
	logic                            any_free;
	logic [challoc_pkg::CH_W-1:0]    fin_idx;
	logic                            ram_we;
	logic [challoc_pkg::ENTRY_W-1:0] ram_rdata;
	logic [challoc_pkg::PTR_W-1:0]   head_nx, tail_nx;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= challoc_pkg::cmd_t'(cmd);
			sound_q <= sound_id;
			reps_q  <= repeat_count;
			fin_q   <= finished_channel;
		end
	end

	// lowest-numbered free channel
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = challoc_pkg::CHANNELS - 1; i >= 0; i--) begin
			if (!chan_busy_q[i]) begin
				free_idx = challoc_pkg::CH_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign fin_idx = challoc_pkg::fin_to_idx(fin_q);

	assign st.cmd      = cmd_q;
	assign st.any_free = any_free;
	assign st.q_empty  = (count_q == '0);
	assign st.q_full   = (count_q == challoc_pkg::CNT_W'(challoc_pkg::WAIT_DEPTH));
	assign st.fin_ok   = ({28'd0, fin_q} < 32'(challoc_pkg::CHANNELS));

	assign head_nx = (head_q == challoc_pkg::PTR_W'(challoc_pkg::WAIT_DEPTH - 1))
		? '0 : head_q + challoc_pkg::PTR_W'(1);
	assign tail_nx = (tail_q == challoc_pkg::PTR_W'(challoc_pkg::WAIT_DEPTH - 1))
		? '0 : tail_q + challoc_pkg::PTR_W'(1);

	assign ram_we = ctl.exec && (ctl.op == challoc_pkg::ST_QUEUED);

	// head entry is read every cycle, so it is ready by the execute cycle
	challoc_ram #(
		.WIDTH (challoc_pkg::ENTRY_W),
		.DEPTH (challoc_pkg::WAIT_DEPTH)
	) u_wait_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({reps_q, sound_q}),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_busy_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (ctl.exec) begin
				case (ctl.op)
					challoc_pkg::ST_STARTED: chan_busy_q[free_idx] <= 1'b1;
					challoc_pkg::ST_QUEUED: begin
						tail_q  <= tail_nx;
						count_q <= count_q + challoc_pkg::CNT_W'(1);
					end
					challoc_pkg::ST_FREED: begin
						if (st.fin_ok) begin
							chan_busy_q[fin_idx] <= 1'b0;
						end
					end
					challoc_pkg::ST_HANDED: begin
						chan_busy_q[fin_idx] <= 1'b1;
						head_q               <= head_nx;
						count_q              <= count_q - challoc_pkg::CNT_W'(1);
					end
					challoc_pkg::ST_STOPPED: chan_busy_q <= '0;
					challoc_pkg::ST_CLEARED: begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status          <= ctl.op;
			channel_out     <= 4'd0;
			started_sound   <= 8'd0;
			started_repeats <= 9'sd0;
			case (ctl.op)
				challoc_pkg::ST_STARTED: begin
					channel_out     <= challoc_pkg::chan_to_out(free_idx);
					started_sound   <= sound_q;
					started_repeats <= reps_q;
				end
				challoc_pkg::ST_FREED: channel_out <= fin_q;
				challoc_pkg::ST_HANDED: begin
					channel_out     <= fin_q;
					started_sound   <= ram_rdata[7:0];
					started_repeats <= ram_rdata[16:8];
				end
				default: begin
				end
			endcase
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/core/challoc_chk.sv =====
`timescale 1ns / 1ps

module challoc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [2:0]        status,
	input logic [3:0]        channel_out,
	input logic [7:0]        started_sound,
	input logic signed [8:0] started_repeats
);

	// every accepted beat gives its result, flagged by done, once it has executed
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("no result two cycles after an accepted beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted beat");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// results that involve no channel carry zero channel and started fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == challoc_pkg::ST_QUEUED || status == challoc_pkg::ST_REJECTED ||
			status == challoc_pkg::ST_STOPPED || status == challoc_pkg::ST_CLEARED))
		|-> (channel_out == 4'd0 && started_sound == 8'd0 && started_repeats == 9'sd0))
		else $error("nonzero fields on a result without a channel");

endmodule

bind channel_allocator_with_wait_queue challoc_chk u_challoc_chk (.*);
